// File: hdl/stss_pkg.sv
// ============================================================================
// stss_pkg - shared types and constants of the speed target slew shaper
// Register indexes, field widths and the fixed constants of the curve
// slowdown arithmetic.
// ============================================================================
`default_nettype none

package stss_pkg;

    // Field widths.
    localparam int SPEED_W    = 16;
    localparam int WHEEL_W    = 17;
    localparam int STEP_REG_W = 12;
    localparam int MIN_BASE_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RAMP_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_EN     = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [STEP_REG_W-1:0] BASE_STEP_RST  = 12'd20;
    localparam logic [STEP_REG_W-1:0] STEER_STEP_RST = 12'd80;
    localparam logic [MIN_BASE_W-1:0] CURVE_MIN_RST  = 15'd500;

    // Curve slowdown: the pull starts above an error of CURVE_START and is
    // complete at CURVE_FULL.
    localparam logic [16:0] CURVE_START = 17'd100;
    localparam logic [16:0] CURVE_FULL  = 17'd300;
    localparam int          CURVE_T_W   = 8;

    // Division of the pull product by the curve span (200) is done with an
    // exact reciprocal: q = (x * CURVE_RECIP) >> CURVE_SHIFT for x < 2^25.
    localparam int                 CURVE_PROD_W  = 25;
    localparam int                 CURVE_SHIFT   = 33;
    localparam int                 CURVE_RECIP_W = 26;
    localparam logic [25:0]        CURVE_RECIP   = 26'd42949673;
    localparam int                 CURVE_RED_W   = 17;

    // Elapsed time scaled step product.
    localparam int STEP_PROD_W = STEP_REG_W + 16;

    // Slew step saturation; any step of this size or more lets every target
    // through, since held and target differ by at most 65535.
    localparam int              STEP_W   = 17;
    localparam logic [31:0]     STEP_SAT = 32'd65536;

endpackage

`default_nettype wire

// File: hdl/speed_target_slew_shaper.sv
// ============================================================================
// speed_target_slew_shaper - wheel speed target shaping with slew limiting
// Curve dependent base slowdown followed by slew limiting of the base speed
// and the steering correction, producing left and right wheel targets.
// ============================================================================
//
// Usage:
// The input stream (s_axis_*) carries one control update per transfer: the
// position error, the elapsed milliseconds, the requested base speed and the
// requested steering correction. For every input transfer exactly one result
// transfer leaves on m_axis_*: the shaped base, the shaped correction and the
// left and right wheel targets. The cfg_* channel writes the six settings
// registers; it is always ready and should only be used while no update is
// in flight.
// One update is taken every cycle while s_axis_tready is high. The input
// register is loaded at the transfer edge and four stages follow it:
// multiplier stage, reciprocal divider stage, target and step stage, and the
// slew stage that owns the held speeds and whose registers drive m_axis_*.
// A stalled receiver fills the empty stages first; s_axis_tready drops only
// when all five stages hold an update.
// Reset clears the held base and correction to zero, empties the pipeline
// and loads the register defaults (steps 20 and 80, minimum base 500, all
// three features enabled).
//
`default_nettype none

module speed_target_slew_shaper #(
    parameter int CONTROL_PERIOD_MS = 50
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] position_error, [31:16] elapsed_time, [47:32] requested_base,
    // [63:48] requested_correction
    input  wire logic [63:0] s_axis_tdata,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] shaped_base, [31:16] shaped_correction, [48:32] left_target,
    // [65:49] right_target, [71:66] zero
    output logic [71:0]      m_axis_tdata,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [stss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [stss_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Exact reciprocal of the control period for products below 2^STEP_PROD_W.
    localparam int PER_SHIFT = $clog2(CONTROL_PERIOD_MS);
    localparam int PER_RECIP_W = stss_pkg::STEP_PROD_W + 2;
    localparam logic [63:0] PER_RECIP =
        ((64'd1 << (stss_pkg::STEP_PROD_W + PER_SHIFT)) / CONTROL_PERIOD_MS) + 64'd1;
    localparam int PER_PROD_W = stss_pkg::STEP_PROD_W + PER_RECIP_W;
    localparam int Q_W = PER_RECIP_W - PER_SHIFT;

    localparam int CURVE_PP_W = stss_pkg::CURVE_PROD_W + stss_pkg::CURVE_RECIP_W;

    // ------------------------------------------------------------------
    // Settings registers
    // ------------------------------------------------------------------
    logic [stss_pkg::STEP_REG_W-1:0] base_step_reg;
    logic [stss_pkg::STEP_REG_W-1:0] steer_step_reg;
    logic [stss_pkg::MIN_BASE_W-1:0] curve_min_reg;
    logic                            curve_en_reg;
    logic                            base_ramp_en_reg;
    logic                            steer_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg    <= stss_pkg::BASE_STEP_RST;
            steer_step_reg   <= stss_pkg::STEER_STEP_RST;
            curve_min_reg    <= stss_pkg::CURVE_MIN_RST;
            curve_en_reg     <= 1'b1;
            base_ramp_en_reg <= 1'b1;
            steer_en_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                stss_pkg::REG_BASE_STEP:    base_step_reg    <= cfg_data[11:0];
                stss_pkg::REG_STEER_STEP:   steer_step_reg   <= cfg_data[11:0];
                stss_pkg::REG_CURVE_MIN:    curve_min_reg    <= cfg_data;
                stss_pkg::REG_CURVE_EN:     curve_en_reg     <= cfg_data[0];
                stss_pkg::REG_BASE_RAMP_EN: base_ramp_en_reg <= cfg_data[0];
                stss_pkg::REG_STEER_EN:     steer_en_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or when the next
    // stage loads, so bubbles close up under a stalled receiver.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic en1, en2, en3, en4, en_o;

    assign en_o = !vo_reg || m_axis_tready;
    assign en4  = !v4_reg || en_o;
    assign en3  = !v3_reg || en4;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;

    assign s_axis_tready = en1;
    assign m_axis_tvalid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)  v1_reg <= s_axis_tvalid;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en4)  v4_reg <= v3_reg;
            if (en_o) vo_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic signed [15:0] err1_reg;
    logic        [15:0] ms1_reg;
    logic signed [15:0] base1_reg;
    logic signed [15:0] corr1_reg;

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            err1_reg  <= s_axis_tdata[15:0];
            ms1_reg   <= s_axis_tdata[31:16];
            base1_reg <= s_axis_tdata[47:32];
            corr1_reg <= s_axis_tdata[63:48];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: curve weight and pull product, elapsed time step products.
    // The pull is formed on magnitudes so that the later division truncates
    // toward zero; the sign rides along.
    // ------------------------------------------------------------------
    logic [16:0]                       err_mag;
    logic [16:0]                       err_bounded;
    logic [stss_pkg::CURVE_T_W-1:0]    curve_t;
    logic signed [16:0]                pull_diff;
    logic [16:0]                       pull_mag;
    logic [stss_pkg::CURVE_PROD_W-1:0] pull_prod;

    always_comb
    begin
        err_mag     = err1_reg[15] ? 17'(-$signed({err1_reg[15], err1_reg}))
                                   : {1'b0, err1_reg};
        err_bounded = (err_mag > stss_pkg::CURVE_FULL) ? stss_pkg::CURVE_FULL : err_mag;
        if (curve_en_reg && (err_mag > stss_pkg::CURVE_START))
            curve_t = stss_pkg::CURVE_T_W'(err_bounded - stss_pkg::CURVE_START);
        else
            curve_t = '0;
        pull_diff = $signed({base1_reg[15], base1_reg}) - $signed({2'b00, curve_min_reg});
        pull_mag  = pull_diff[16] ? 17'(-pull_diff) : 17'(pull_diff);
        pull_prod = stss_pkg::CURVE_PROD_W'(pull_mag * curve_t);
    end

    logic [stss_pkg::CURVE_PROD_W-1:0] pull_prod2_reg;
    logic                              pull_neg2_reg;
    logic signed [15:0]                base2_reg;
    logic signed [15:0]                corr2_reg;
    logic [stss_pkg::STEP_PROD_W-1:0]  base_sp2_reg;
    logic [stss_pkg::STEP_PROD_W-1:0]  corr_sp2_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            pull_prod2_reg <= pull_prod;
            pull_neg2_reg  <= pull_diff[16];
            base2_reg      <= base1_reg;
            corr2_reg      <= corr1_reg;
            base_sp2_reg   <= stss_pkg::STEP_PROD_W'(base_step_reg * ms1_reg);
            corr_sp2_reg   <= stss_pkg::STEP_PROD_W'(steer_step_reg * ms1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divisions by constants through reciprocal multiplication.
    // ------------------------------------------------------------------
    logic [CURVE_PP_W-1:0] pull_recip_prod;
    logic [PER_PROD_W-1:0] base_recip_prod;
    logic [PER_PROD_W-1:0] corr_recip_prod;

    always_comb
    begin
        pull_recip_prod = CURVE_PP_W'(pull_prod2_reg * stss_pkg::CURVE_RECIP);
        base_recip_prod = PER_PROD_W'(base_sp2_reg * PER_RECIP[PER_RECIP_W-1:0]);
        corr_recip_prod = PER_PROD_W'(corr_sp2_reg * PER_RECIP[PER_RECIP_W-1:0]);
    end

    logic [stss_pkg::CURVE_RED_W-1:0] red3_reg;
    logic                             pull_neg3_reg;
    logic signed [15:0]               base3_reg;
    logic signed [15:0]               corr3_reg;
    logic [Q_W-1:0]                   base_q3_reg;
    logic [Q_W-1:0]                   corr_q3_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            red3_reg      <= pull_recip_prod[stss_pkg::CURVE_SHIFT +: stss_pkg::CURVE_RED_W];
            pull_neg3_reg <= pull_neg2_reg;
            base3_reg     <= base2_reg;
            corr3_reg     <= corr2_reg;
            base_q3_reg   <= base_recip_prod[stss_pkg::STEP_PROD_W + PER_SHIFT +: Q_W];
            corr_q3_reg   <= corr_recip_prod[stss_pkg::STEP_PROD_W + PER_SHIFT +: Q_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slowed base target and the bounded slew steps.
    // ------------------------------------------------------------------
    logic signed [17:0]             red_signed;
    logic signed [17:0]             base_slow;
    logic [31:0]                    base_q_ext;
    logic [31:0]                    corr_q_ext;
    logic [stss_pkg::STEP_W-1:0]    base_step;
    logic [stss_pkg::STEP_W-1:0]    corr_step;

    always_comb
    begin
        red_signed = pull_neg3_reg ? -$signed({1'b0, red3_reg}) : $signed({1'b0, red3_reg});
        base_slow  = $signed({{2{base3_reg[15]}}, base3_reg}) - red_signed;

        base_q_ext = 32'(base_q3_reg);
        corr_q_ext = 32'(corr_q3_reg);
        if (base_q_ext > stss_pkg::STEP_SAT)
            base_step = stss_pkg::STEP_W'(stss_pkg::STEP_SAT);
        else if (base_q_ext == 32'd0)
            base_step = stss_pkg::STEP_W'(1);
        else
            base_step = base_q_ext[stss_pkg::STEP_W-1:0];
        if (corr_q_ext > stss_pkg::STEP_SAT)
            corr_step = stss_pkg::STEP_W'(stss_pkg::STEP_SAT);
        else if (corr_q_ext == 32'd0)
            corr_step = stss_pkg::STEP_W'(1);
        else
            corr_step = corr_q_ext[stss_pkg::STEP_W-1:0];
    end

    logic signed [15:0]          base_tgt4_reg;
    logic signed [15:0]          corr_tgt4_reg;
    logic [stss_pkg::STEP_W-1:0] base_step4_reg;
    logic [stss_pkg::STEP_W-1:0] corr_step4_reg;

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            // The slowed base always lies between the request and the
            // minimum base, so it fits the speed field.
            base_tgt4_reg  <= base_slow[15:0];
            corr_tgt4_reg  <= corr3_reg;
            base_step4_reg <= base_step;
            corr_step4_reg <= corr_step;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: slew limiting against the held speeds, which double as the
    // result register for the shaped base and correction.
    // ------------------------------------------------------------------
    logic signed [15:0] held_base_reg, held_base_next;
    logic signed [15:0] held_corr_reg, held_corr_next;
    logic signed [16:0] left_reg, left_next;
    logic signed [16:0] right_reg, right_next;

    logic signed [18:0] base_up, base_dn, base_tgt_w;
    logic signed [18:0] corr_up, corr_dn, corr_tgt_w;

    always_comb
    begin
        base_tgt_w = 19'(base_tgt4_reg);
        base_up    = 19'(held_base_reg) + $signed({2'b00, base_step4_reg});
        base_dn    = 19'(held_base_reg) - $signed({2'b00, base_step4_reg});
        if (!base_ramp_en_reg)
            held_base_next = base_tgt4_reg;
        else if (base_tgt_w > base_up)
            held_base_next = base_up[15:0];
        else if (base_tgt_w < base_dn)
            held_base_next = base_dn[15:0];
        else
            held_base_next = base_tgt4_reg;

        corr_tgt_w = 19'(corr_tgt4_reg);
        corr_up    = 19'(held_corr_reg) + $signed({2'b00, corr_step4_reg});
        corr_dn    = 19'(held_corr_reg) - $signed({2'b00, corr_step4_reg});
        if (!steer_en_reg)
            held_corr_next = corr_tgt4_reg;
        else if (corr_tgt_w > corr_up)
            held_corr_next = corr_up[15:0];
        else if (corr_tgt_w < corr_dn)
            held_corr_next = corr_dn[15:0];
        else
            held_corr_next = corr_tgt4_reg;

        left_next  = 17'(held_base_next) + 17'(held_corr_next);
        right_next = 17'(held_base_next) - 17'(held_corr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_base_reg <= '0;
            held_corr_reg <= '0;
        end
        else if (en_o && v4_reg)
        begin
            held_base_reg <= held_base_next;
            held_corr_reg <= held_corr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o && v4_reg)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign m_axis_tdata = {6'd0, right_reg, left_reg, held_corr_reg, held_base_reg};

endmodule

`default_nettype wire

// File: verif/stss_target_check.sv
// ============================================================================
// stss_target_check - result checker for the speed target slew shaper
// Watches the update, result and settings channels, keeps its own copy of the
// settings and held speeds, predicts every result and compares it in order.
// ============================================================================

module stss_target_check #(
    parameter int CONTROL_PERIOD_MS = 50
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [63:0]                     s_axis_tdata,

    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [71:0]                     m_axis_tdata,

    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [stss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [stss_pkg::CFG_DATA_W-1:0] cfg_data,

    output int                                   mismatch_count,
    output int                                   pending_count
);

    localparam int KNEE_ERR     = 100;
    localparam int FULL_ERR     = 300;
    localparam int MAX_REPORTED = 10;

    // Packed so that the shaped base sits in the lowest bits, as on the bus.
    typedef struct packed {
        logic signed [stss_pkg::WHEEL_W-1:0] right;
        logic signed [stss_pkg::WHEEL_W-1:0] left;
        logic signed [stss_pkg::SPEED_W-1:0] correction;
        logic signed [stss_pkg::SPEED_W-1:0] base;
    } wheel_targets_t;

    localparam int RESULT_W = $bits(wheel_targets_t);

    logic [stss_pkg::STEP_REG_W-1:0] base_step;
    logic [stss_pkg::STEP_REG_W-1:0] steer_step;
    logic [stss_pkg::MIN_BASE_W-1:0] min_base;
    logic                            curve_en;
    logic                            ramp_en;
    logic                            steer_en;
    logic signed [stss_pkg::SPEED_W-1:0] held_base;
    logic signed [stss_pkg::SPEED_W-1:0] held_corr;

    wheel_targets_t pending_targets[$];
    wheel_targets_t want;
    wheel_targets_t got;

    function automatic longint step_size(input logic [stss_pkg::STEP_REG_W-1:0] per_period,
                                         input logic [15:0] ms);
        longint s;
        s = (longint'(per_period) * longint'(ms)) / CONTROL_PERIOD_MS;
        if (s < 1)
            s = 1;
        return s;
    endfunction

    function automatic int slew_toward(input int cur, input int tgt, input longint step);
        if (longint'(tgt) > longint'(cur) + step)
            return int'(longint'(cur) + step);
        if (longint'(tgt) < longint'(cur) - step)
            return int'(longint'(cur) - step);
        return tgt;
    endfunction

    // Pulls the requested base toward the minimum base once the error is past
    // the knee; the division truncates toward zero on both signs.
    function automatic int slowed_base(input logic signed [15:0] err,
                                       input logic signed [15:0] base_req);
        int mag;
        int bounded;
        int result;
        mag    = (err < 0) ? -int'(err) : int'(err);
        result = int'(base_req);
        if (curve_en && mag > KNEE_ERR)
        begin
            bounded = (mag > FULL_ERR) ? FULL_ERR : mag;
            result  = int'(base_req) - ((int'(base_req) - int'(min_base))
                      * (bounded - KNEE_ERR)) / (FULL_ERR - KNEE_ERR);
        end
        return result;
    endfunction

    function automatic wheel_targets_t shape_update(input logic [63:0] word);
        logic signed [15:0] err;
        logic [15:0]        ms;
        logic signed [15:0] base_req;
        logic signed [15:0] corr_req;
        int                 target_base;
        wheel_targets_t     t;
        err         = word[15:0];
        ms          = word[31:16];
        base_req    = word[47:32];
        corr_req    = word[63:48];
        target_base = slowed_base(err, base_req);
        if (ramp_en)
            held_base = stss_pkg::SPEED_W'(slew_toward(int'(held_base), target_base,
                                                       step_size(base_step, ms)));
        else
            held_base = stss_pkg::SPEED_W'(target_base);
        if (steer_en)
            held_corr = stss_pkg::SPEED_W'(slew_toward(int'(held_corr), int'(corr_req),
                                                       step_size(steer_step, ms)));
        else
            held_corr = corr_req;
        t.base       = held_base;
        t.correction = held_corr;
        t.left       = stss_pkg::WHEEL_W'(int'(held_base) + int'(held_corr));
        t.right      = stss_pkg::WHEEL_W'(int'(held_base) - int'(held_corr));
        return t;
    endfunction

    task automatic note_mismatch(input string what, input wheel_targets_t exp_t,
                                 input wheel_targets_t act_t, input logic [5:0] pad);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display({"%0t: %s: expected base %0d corr %0d left %0d right %0d, ",
                      "got base %0d corr %0d left %0d right %0d pad %0h"},
                     $realtime, what, exp_t.base, exp_t.correction, exp_t.left,
                     exp_t.right, act_t.base, act_t.correction, act_t.left,
                     act_t.right, pad);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step  = stss_pkg::BASE_STEP_RST;
            steer_step = stss_pkg::STEER_STEP_RST;
            min_base   = stss_pkg::CURVE_MIN_RST;
            curve_en   = 1'b1;
            ramp_en    = 1'b1;
            steer_en   = 1'b1;
            held_base  = '0;
            held_corr  = '0;
            pending_targets.delete();
            pending_count  = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    stss_pkg::REG_BASE_STEP:
                        base_step  = cfg_data[stss_pkg::STEP_REG_W-1:0];
                    stss_pkg::REG_STEER_STEP:
                        steer_step = cfg_data[stss_pkg::STEP_REG_W-1:0];
                    stss_pkg::REG_CURVE_MIN:
                        min_base   = cfg_data[stss_pkg::MIN_BASE_W-1:0];
                    stss_pkg::REG_CURVE_EN:     curve_en = cfg_data[0];
                    stss_pkg::REG_BASE_RAMP_EN: ramp_en  = cfg_data[0];
                    stss_pkg::REG_STEER_EN:     steer_en = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RESULT_W-1:0];
                if (pending_targets.size() == 0)
                begin
                    note_mismatch("result with no update outstanding", '0, got,
                                  m_axis_tdata[71:66]);
                end
                else
                begin
                    want = pending_targets.pop_front();
                    if (got !== want || m_axis_tdata[71:66] !== '0)
                        note_mismatch("result mismatch", want, got, m_axis_tdata[71:66]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_targets.push_back(shape_update(s_axis_tdata));
            pending_count = pending_targets.size();
        end
    end

endmodule

// File: verif/tb_speed_target_slew_shaper.sv
// ============================================================================
// tb_speed_target_slew_shaper - testbench of the speed target slew shaper
// Drives control updates and settings writes with random idling on both
// stream sides, and leaves prediction and comparison to the checker.
// ============================================================================

module tb_speed_target_slew_shaper;

    localparam int CLK_HALF        = 10;
    localparam int PERIOD_MS       = 50;
    // SETTLE_CYCLES of margin are allowed after the last result before
    // settings change or the run ends.
    localparam int PIPE_LATENCY    = 4;
    localparam int SETTLE_CYCLES   = PIPE_LATENCY + 3;
    localparam int LONG_HOLD       = 64;
    localparam int PRESSURE_ITEMS  = 60;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 165;
    // The longest legal stretch without any transfer is the long receiver
    // hold; the watchdog allows many times that.
    localparam int WATCHDOG_LIMIT  = 2000;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [stss_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [stss_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // [15:0] position_error, [31:16] elapsed_time, [47:32] requested_base,
    // [63:48] requested_correction
    logic [63:0]                     s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [15:0] shaped_base, [31:16] shaped_correction, [48:32] left_target,
    // [65:49] right_target, [71:66] zero
    logic [71:0]                     m_axis_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [stss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [stss_pkg::CFG_DATA_W-1:0] cfg_data;

    int                              mismatch_count;
    int                              pending_count;
    int                              idle_cycles;

    // Stimulus-side controls. While quiet is set neither side idles; setting
    // long_hold_req makes the receiver take one long LONG_HOLD stall, and the
    // receiver raises long_hold_ack once the stall has started.
    logic                            quiet;
    logic                            long_hold_req;
    logic                            long_hold_ack;
    logic signed [15:0]              cruise_base;

    speed_target_slew_shaper #(
        .CONTROL_PERIOD_MS(PERIOD_MS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stss_target_check #(
        .CONTROL_PERIOD_MS(PERIOD_MS)
    ) wheel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [63:0] pack_update(input int err, input int ms,
                                                input int base, input int corr);
        return {16'(corr), 16'(base), 16'(ms), 16'(err)};
    endfunction

    // Boundary values of a 16 bit field, plus the region around the curve knee.
    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            5:       return 16'(-int'($urandom_range(95, 305)));
            default: return 16'($urandom_range(95, 305));
        endcase
    endfunction

    // Step register value, mostly small, sometimes anywhere in range.
    function automatic logic [stss_pkg::STEP_REG_W-1:0] rand_step();
        if ($urandom_range(0, 1) != 0)
            return stss_pkg::STEP_REG_W'($urandom_range(0, 300));
        return stss_pkg::STEP_REG_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [stss_pkg::MIN_BASE_W-1:0] rand_min_base();
        if ($urandom_range(0, 1) != 0)
            return stss_pkg::MIN_BASE_W'($urandom_range(0, 3000));
        return stss_pkg::MIN_BASE_W'($urandom_range(0, 32767));
    endfunction

    // Register value with random junk above the register width, which the
    // block must drop.
    function automatic logic [stss_pkg::CFG_DATA_W-1:0] with_junk(
            input logic [stss_pkg::CFG_DATA_W-1:0] value, input int width);
        logic [stss_pkg::CFG_DATA_W-1:0] junk;
        junk = stss_pkg::CFG_DATA_W'($urandom);
        return (junk << width) | value;
    endfunction

    // Offers one update and returns once it has been transferred. The valid
    // stays high into the next update unless a gap is taken.
    task automatic send_update(input logic [63:0] word);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Most updates look like real driving: a cruise base that changes now and
    // then, moderate errors and short control periods, so that the held speeds
    // actually track and settle. The rest is noise and boundary values.
    task automatic send_random_update();
        int                 r;
        logic signed [15:0] err;
        logic [15:0]        ms;
        logic signed [15:0] base;
        logic signed [15:0] corr;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            if ($urandom_range(0, 15) == 0)
                cruise_base = 16'(int'($urandom_range(0, 7000)) - 1000);
            err  = 16'(int'($urandom_range(0, 900)) - 450);
            ms   = 16'($urandom_range(0, 120));
            base = 16'(int'(cruise_base) + int'($urandom_range(0, 40)) - 20);
            corr = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
        else if (r < 90)
        begin
            err  = 16'($urandom);
            ms   = 16'($urandom);
            base = 16'($urandom);
            corr = 16'($urandom);
        end
        else
        begin
            err  = corner_value();
            ms   = corner_value();
            base = corner_value();
            corr = corner_value();
        end
        send_update({corr, base, ms, err});
    endtask

    // Waits until every expected result has been transferred, then lets the
    // pipeline settle. The first edge makes sure the checker has seen the
    // last update before its count is looked at.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [stss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stss_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes all six registers back to back, with one write to an index past
    // the list mixed in. Only called while the block is idle.
    task automatic program_registers(input logic [stss_pkg::STEP_REG_W-1:0] base_step,
                                     input logic [stss_pkg::STEP_REG_W-1:0] steer_step,
                                     input logic [stss_pkg::MIN_BASE_W-1:0] min_base,
                                     input logic curve_en, input logic ramp_en,
                                     input logic steer_en);
        write_reg(stss_pkg::REG_BASE_STEP,
                  with_junk(stss_pkg::CFG_DATA_W'(base_step), stss_pkg::STEP_REG_W));
        write_reg(stss_pkg::REG_STEER_STEP,
                  with_junk(stss_pkg::CFG_DATA_W'(steer_step), stss_pkg::STEP_REG_W));
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                  stss_pkg::CFG_DATA_W'($urandom));
        write_reg(stss_pkg::REG_CURVE_MIN,
                  with_junk(stss_pkg::CFG_DATA_W'(min_base), stss_pkg::MIN_BASE_W));
        write_reg(stss_pkg::REG_CURVE_EN,
                  with_junk(stss_pkg::CFG_DATA_W'(curve_en), 1));
        write_reg(stss_pkg::REG_BASE_RAMP_EN,
                  with_junk(stss_pkg::CFG_DATA_W'(ramp_en), 1));
        write_reg(stss_pkg::REG_STEER_EN,
                  with_junk(stss_pkg::CFG_DATA_W'(steer_en), 1));
        cfg_valid <= 1'b0;
    endtask

    // Receiver: takes results with random stalls of mixed length, and on
    // request holds off for one long stretch so the pipeline backs up into
    // the input.
    initial
    begin : result_sink
        int gap;
        long_hold_ack = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            gap = quiet ? 0 : pick_gap();
            if (long_hold_req && !long_hold_ack)
            begin
                long_hold_ack = 1'b1;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog: a run that stops moving for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_speed_target_slew_shaper failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int p;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        cruise_base   = 16'sd1500;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed updates under the reset settings (steps 20 and 80, minimum
        // base 500, every feature on), starting from held speeds of zero.
        send_update(pack_update(0, 50, 1000, 300));          // plain ramp up
        send_update(pack_update(0, 0, 1000, -300));          // zero time, step of one
        send_update(pack_update(0, 1, 1000, -300));          // step truncates to zero
        send_update(pack_update(0, 65535, 1000, 200));       // step far past target
        send_update(pack_update(100, 65535, 1000, 0));       // error at the knee
        send_update(pack_update(101, 65535, 1000, 0));       // just past the knee
        send_update(pack_update(300, 65535, 1000, 0));       // full slowdown
        send_update(pack_update(301, 65535, 1000, 0));       // beyond full
        send_update(pack_update(-101, 65535, 1000, 0));
        send_update(pack_update(-300, 65535, 1000, 0));
        send_update(pack_update(-32768, 65535, 1000, 0));    // most negative error
        send_update(pack_update(32767, 65535, 1000, 0));
        send_update(pack_update(0, 65535, 32767, 32767));    // largest speeds
        send_update(pack_update(0, 65535, -32768, -32768));  // smallest speeds
        send_update(pack_update(200, 65535, -32768, 32767)); // negative pull
        send_update(pack_update(201, 65535, -32768, 0));     // negative truncation
        send_update(pack_update(199, 65535, 333, -32768));   // positive base below minimum
        send_update(pack_update(250, 65535, 500, 0));        // base equal to minimum
        send_update(pack_update(-250, 7, 32767, 32767));     // partial step
        send_update(pack_update(150, 50, 0, 0));

        // Phases of random updates, each under its own settings; the first
        // few pin the extremes, the rest are random.
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:       program_registers(12'd0, 12'd0, 15'd0, 1'b1, 1'b1, 1'b1);
                1:       program_registers(12'd4095, 12'd4095, 15'd32767, 1'b1, 1'b1, 1'b1);
                2:       program_registers(12'd20, 12'd80, 15'd500, 1'b1, 1'b0, 1'b0);
                3:       program_registers(12'd4095, 12'd0, 15'd0, 1'b0, 1'b1, 1'b0);
                4:       program_registers(12'd0, 12'd4095, 15'd32767, 1'b1, 1'b0, 1'b1);
                default: program_registers(rand_step(), rand_step(), rand_min_base(),
                                           $urandom_range(0, 3) != 0,
                                           $urandom_range(0, 3) != 0,
                                           $urandom_range(0, 3) != 0);
            endcase

            // One phase runs with no idling on either side.
            quiet = (p == 3);

            // Back pressure: the receiver stalls for a long stretch while
            // updates keep coming, so the pipeline fills and stalls the input.
            if (p == 6)
            begin
                long_hold_req = 1'b1;
                wait (long_hold_ack);
                quiet = 1'b1;
                repeat (PRESSURE_ITEMS) send_random_update();
                quiet = 1'b0;
            end

            repeat (ITEMS_PER_PHASE) send_random_update();
        end
        quiet = 1'b0;

        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_speed_target_slew_shaper passed");
        else
            $display("tb_speed_target_slew_shaper failed");
        $finish;
    end

endmodule

// File: speed_target_slew_shaper.f
hdl/stss_pkg.sv
hdl/speed_target_slew_shaper.sv
verif/stss_target_check.sv
verif/tb_speed_target_slew_shaper.sv
